FILE: hdl/ivs_pkg.sv
// Shared types and constants for the integer varint serializer.
// Used by ivs_front, ivs_queue, ivs_back and the top level; no dependencies.
package ivs_pkg;

  // Format codes carried in cmd
  typedef enum logic [2:0] {
    CMD_FIX8   = 3'd0,
    CMD_FIX16  = 3'd1,
    CMD_FIX32  = 3'd2,
    CMD_FIX64  = 3'd3,
    CMD_VAR32  = 3'd4,
    CMD_VAR64  = 3'd5,
    CMD_ZZ32   = 3'd6,
    CMD_ZZ64   = 3'd7
  } cmd_t;

  // Configuration register indexes
  localparam logic REG_LITTLE_ENDIAN = 1'b0;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [7:0] VARINT_CONT = 8'h80;
  localparam logic [6:0] VARINT_MASK = 7'h7F;

  // One classified job handed from front to back
  typedef struct packed {
    logic        varint;   // 1: 7-bit groups, 0: fixed bytes
    logic [2:0]  nbytes_m1; // fixed formats: byte count minus one
    logic [63:0] word;     // pre-ordered payload, lowest bits go out first
  } job_t;

endpackage

FILE: hdl/ivs_front.sv
// Front end: holds the byte-order register and classifies incoming values.
// Depends on ivs_pkg; produces one job_t per accepted input transaction.
module ivs_front import ivs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input value
  input  logic [2:0]  cmd,
  input  logic [63:0] value,
  output job_t        job
);

  logic        little_endian;
  logic [31:0] lo32;
  logic [31:0] zz32;
  logic [63:0] zz64;

  // Write the byte-order register
  always_ff @(posedge clk) begin
    if (rst) begin
      little_endian <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_LITTLE_ENDIAN)) begin
      little_endian <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LITTLE_ENDIAN) ? {31'd0, little_endian} : 32'd0;

  // Zigzag maps
  assign lo32 = value[31:0];
  assign zz32 = {lo32[30:0], 1'b0} ^ {32{lo32[31]}};
  assign zz64 = {value[62:0], 1'b0} ^ {64{value[63]}};

  // Classify and pre-order so the back end always shifts right
  always_comb begin
    job = '0;
    case (cmd_t'(cmd))
      CMD_FIX8: begin
        job.nbytes_m1 = 3'd0;
        job.word      = {56'd0, value[7:0]};
      end
      CMD_FIX16: begin
        job.nbytes_m1 = 3'd1;
        job.word      = little_endian ? {48'd0, value[15:0]}
                                      : {48'd0, value[7:0], value[15:8]};
      end
      CMD_FIX32: begin
        job.nbytes_m1 = 3'd3;
        job.word      = little_endian ? {32'd0, lo32}
                                      : {32'd0, value[7:0], value[15:8],
                                         value[23:16], value[31:24]};
      end
      CMD_FIX64: begin
        job.nbytes_m1 = 3'd7;
        job.word      = little_endian ? value
                                      : {value[7:0], value[15:8], value[23:16],
                                         value[31:24], value[39:32], value[47:40],
                                         value[55:48], value[63:56]};
      end
      CMD_VAR32: begin
        job.varint = 1'b1;
        job.word   = {32'd0, lo32};
      end
      CMD_VAR64: begin
        job.varint = 1'b1;
        job.word   = value;
      end
      CMD_ZZ32: begin
        job.varint = 1'b1;
        job.word   = {32'd0, zz32};
      end
      CMD_ZZ64: begin
        job.varint = 1'b1;
        job.word   = zz64;
      end
      default: begin
        job = '0;
      end
    endcase
  end

endmodule

FILE: hdl/ivs_queue.sv
// Short job queue between front and back; each side stalls on its own.
// Depends on ivs_pkg for job_t.
module ivs_queue import ivs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_job,
  output logic full,
  input  logic rd_en,
  output job_t rd_job,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  job_t          mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  assign full   = (count == DEPTH_CNT);
  assign empty  = (count == '0);
  assign rd_job = mem[rptr];

  // Store jobs
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/ivs_back.sv
// Back end: serializes one job into bytes, one output transaction per cycle while out_ready is high.
// Depends on ivs_pkg; pulls jobs from ivs_queue.
module ivs_back import ivs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  job_t       q_job,
  input  logic       q_empty,
  output logic       q_pop,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_valid,
  input  logic       out_ready
);

  logic        busy;
  logic        varint;
  logic [2:0]  remain;
  logic [63:0] word;
  logic        more;
  logic        fire;

  // Varint continues while bits remain above the current group
  assign more      = (word[63:7] != 57'd0);
  assign out_last  = varint ? !more : (remain == 3'd0);
  assign out_byte  = varint ? ({1'b0, word[6:0] & VARINT_MASK} | (more ? VARINT_CONT : 8'h00))
                            : word[7:0];
  assign out_valid = busy;
  assign fire      = busy && out_ready;

  // Load the next job when idle or when the final byte leaves
  assign q_pop = !q_empty && (!busy || (fire && out_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (q_pop) begin
      busy <= 1'b1;
    end else if (fire && out_last) begin
      busy <= 1'b0;
    end
  end

  // Shift out the word
  always_ff @(posedge clk) begin
    if (q_pop) begin
      varint <= q_job.varint;
      remain <= q_job.nbytes_m1;
      word   <= q_job.word;
    end else if (fire) begin
      remain <= remain - 1'b1;
      word   <= varint ? {7'd0, word[63:7]} : {8'd0, word[63:8]};
    end
  end

endmodule

FILE: hdl/integer_varint_serializer_core.sv
// Top level of the integer varint serializer: front, job queue and back.
// Depends on ivs_pkg, ivs_front, ivs_queue and ivs_back.
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+-------------------------------------
//  s_axis    | in  | s_tvalid / s_tready    | s_tdata: cmd[2:0], value[66:3]
//  m_axis    | out | m_tvalid / m_tready    | m_tdata: out_byte[7:0]; m_tlast: last
//  apb       | in  | psel, penable, pready  | reg 0 at 0x0: little_endian
//
// A value has 1, 2, 4 or 8 bytes in fixed formats and 1 to 10 as a varint; the
// back-end serializer emits one byte a cycle while m_tready is high. A job passes
// the queue memory and the back-end word register before its first byte; the next
// job loads as the final byte leaves, so successive values' bytes run gapless.
// Synchronous reset clears the queue, the serializer and little_endian (big-endian).
// Input stalls only when the job queue is full; output stalls hold the byte.
module integer_varint_serializer_core import ivs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // [2:0] cmd, [66:3] value, [71:67] zero
  input  logic        m_tready,
  output logic        m_tvalid,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast
);

  job_t job_in;
  job_t job_out;
  logic q_full;
  logic q_empty;
  logic q_pop;

  assign s_tready = !q_full;

  ivs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd     (s_tdata[2:0]),
    .value   (s_tdata[66:3]),
    .job     (job_in)
  );

  ivs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (s_tvalid && !q_full),
    .wr_job (job_in),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_job (job_out),
    .empty  (q_empty)
  );

  ivs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_job     (job_out),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_byte  (m_tdata),
    .out_last  (m_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

endmodule
